### rtl/core/sab_pkg.sv
// shared constants, lookup tables and pipeline control type for the blend unit
package sab_pkg;

    localparam int ChanW      = 8;
    localparam int PixW       = 32;
    localparam int GalW       = 9;
    localparam int LinW       = 17;
    localparam int SumW       = 18;
    localparam int WideW      = 36;
    localparam int RootW      = WideW / 2;

    localparam logic [GalW-1:0]  GalOne  = 9'd256;
    localparam logic [ChanW-1:0] ChanMax = 8'hff;

    localparam longint unsigned LinOne     = 65536;
    localparam longint unsigned ColourDen  = 130050;
    localparam longint unsigned ColourBias = 65025;
    localparam longint unsigned AlphaDen   = 510;
    localparam longint unsigned AlphaBias  = 255;

    // pipeline stage positions
    localparam int SqrtStepsPerStage = 3;
    localparam int SqrtStages        = RootW / SqrtStepsPerStage;
    localparam int StLook            = 0;
    localparam int StScale           = 1;
    localparam int StBlend           = 2;
    localparam int StWide            = 3;
    localparam int StSqrt0           = 4;
    localparam int StOut             = StSqrt0 + SqrtStages;
    localparam int NumStages         = StOut + 1;

    typedef logic [255:0][LinW-1:0] lin_tab_t;

    typedef struct packed {
        logic [NumStages-1:0] load;
    } pipe_ctrl_t;

    // colour to linear: round_half_up(c*c*65536/65025)
    function automatic lin_tab_t build_colour_tab();
        lin_tab_t        t;
        longint unsigned n;
        for (int c = 0; c < 256; c++)
        begin
            n    = longint'(c) * longint'(c) * LinOne;
            t[c] = LinW'((2 * n + ColourBias) / ColourDen);
        end
        return t;
    endfunction

    // alpha to linear: round_half_up(a*65536/255)
    function automatic lin_tab_t build_alpha_tab();
        lin_tab_t        t;
        longint unsigned n;
        for (int a = 0; a < 256; a++)
        begin
            n    = longint'(a) * LinOne;
            t[a] = LinW'((2 * n + AlphaBias) / AlphaDen);
        end
        return t;
    endfunction

    localparam lin_tab_t ColourLinTab = build_colour_tab();
    localparam lin_tab_t AlphaLinTab  = build_alpha_tab();

endpackage

### rtl/core/sab_front.sv
// front stages: linearize lookup, global alpha scaling, over blend in linear light
module sab_front import sab_pkg::*;
(
    input  logic                       clk,
    input  pipe_ctrl_t                 ctrl,
    input  logic [GalW-1:0]            gal,
    input  logic [PixW-1:0]            src_pixel,
    input  logic [PixW-1:0]            dst_pixel,
    output logic [2:0][SumW-1:0]       colour_lin,
    output logic [SumW-1:0]            alpha_lin
);

    // lookup stage
    logic [2:0][LinW-1:0] ls_reg, ls_next;
    logic [2:0][LinW-1:0] ld_reg, ld_next;
    logic [LinW-1:0]      las_reg, las_next;
    logic [LinW-1:0]      lad_reg, lad_next;

    // scale stage
    logic [2:0][LinW-1:0] s_reg, s_next;
    logic [2:0][LinW-1:0] d_reg;
    logic [LinW-1:0]      sa_reg, sa_next;
    logic [LinW-1:0]      da_reg;

    // blend stage
    logic [2:0][SumW-1:0] r_reg, r_next;
    logic [SumW-1:0]      a_reg, a_next;

    function automatic logic [LinW-1:0] scale_lin(logic [LinW-1:0] l, logic [GalW-1:0] g);
        logic [25:0] p;
        p = 26'(l) * 26'(g) + 26'd128;
        return p[24:8];
    endfunction

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            ls_next[c] = ColourLinTab[src_pixel[ChanW*c +: ChanW]];
            ld_next[c] = ColourLinTab[dst_pixel[ChanW*c +: ChanW]];
        end
        las_next = AlphaLinTab[src_pixel[PixW-1 -: ChanW]];
        lad_next = AlphaLinTab[dst_pixel[PixW-1 -: ChanW]];
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            s_next[c] = scale_lin(ls_reg[c], gal);
        end
        sa_next = scale_lin(las_reg, gal);
    end

    always_comb
    begin
        logic [LinW-1:0] inv;
        logic [32:0]     p;
        logic [32:0]     q;
        logic [SumW-1:0] qa;
        inv = LinW'(LinOne) - sa_reg;
        for (int c = 0; c < 3; c++)
        begin
            p         = 33'(inv) * 33'(d_reg[c]) + 33'd32768;
            r_next[c] = SumW'(p[32:16]) + SumW'(s_reg[c]);
        end
        q      = 33'(sa_reg) * 33'(da_reg) + 33'd32768;
        qa     = SumW'(q[32:16]);
        a_next = SumW'(sa_reg) + SumW'(da_reg) - qa;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[StLook])
        begin
            ls_reg  <= ls_next;
            ld_reg  <= ld_next;
            las_reg <= las_next;
            lad_reg <= lad_next;
        end
        if (ctrl.load[StScale])
        begin
            s_reg  <= s_next;
            d_reg  <= ld_reg;
            sa_reg <= sa_next;
            da_reg <= lad_reg;
        end
        if (ctrl.load[StBlend])
        begin
            r_reg <= r_next;
            a_reg <= a_next;
        end
    end

    assign colour_lin = r_reg;
    assign alpha_lin  = a_reg;

endmodule

### rtl/core/sab_isqrt.sv
// pipelined digit-by-digit integer square root, a few root bits per stage
module sab_isqrt import sab_pkg::*;
(
    input  logic              clk,
    input  pipe_ctrl_t        ctrl,
    input  logic [WideW-1:0]  radicand,
    output logic [RootW-1:0]  root
);

    typedef struct packed {
        logic [WideW-1:0]  rad;
        logic [RootW+2:0]  rem;
        logic [RootW-1:0]  root;
    } sqrt_state_t;

    function automatic sqrt_state_t sqrt_step(sqrt_state_t s);
        sqrt_state_t      o;
        logic [RootW+2:0] rem_sh;
        logic [RootW+2:0] trial;
        rem_sh = {s.rem[RootW:0], s.rad[WideW-1 -: 2]};
        trial  = {1'b0, s.root, 2'b01};
        o.rad  = {s.rad[WideW-3:0], 2'b00};
        if (rem_sh >= trial)
        begin
            o.rem  = rem_sh - trial;
            o.root = {s.root[RootW-2:0], 1'b1};
        end
        else
        begin
            o.rem  = rem_sh;
            o.root = {s.root[RootW-2:0], 1'b0};
        end
        return o;
    endfunction

    sqrt_state_t st_reg  [SqrtStages];
    sqrt_state_t st_next [SqrtStages];

    for (genvar k = 0; k < SqrtStages; k++)
    begin : g_stage
        sqrt_state_t seed;

        if (k == 0)
        begin : g_first
            assign seed = '{rad: radicand, rem: '0, root: '0};
        end
        else
        begin : g_rest
            assign seed = st_reg[k-1];
        end

        always_comb
        begin
            sqrt_state_t cur;
            cur = seed;
            for (int j = 0; j < SqrtStepsPerStage; j++)
            begin
                cur = sqrt_step(cur);
            end
            st_next[k] = cur;
        end

        always_ff @(posedge clk)
        begin
            if (ctrl.load[StSqrt0 + k])
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign root = st_reg[SqrtStages-1].root;

endmodule

### rtl/core/sab_back.sv
// back stages: back to gamma space by square root, alpha rescale, saturate and pack
module sab_back import sab_pkg::*;
(
    input  logic                  clk,
    input  pipe_ctrl_t            ctrl,
    input  logic [2:0][SumW-1:0]  colour_lin,
    input  logic [SumW-1:0]       alpha_lin,
    output logic [PixW-1:0]       blended_pixel
);

    logic [2:0][WideW-1:0]               wide_reg, wide_next;
    logic [ChanW-1:0]                    aout_reg, aout_next;
    logic [SqrtStages-1:0][ChanW-1:0]    adly_reg;
    logic [2:0][RootW-1:0]               root;
    logic [PixW-1:0]                     pix_reg, pix_next;

    always_comb
    begin
        logic [26:0] t;
        for (int c = 0; c < 3; c++)
        begin
            wide_next[c] = WideW'(colour_lin[c]) * WideW'(ColourBias);
        end
        t = 27'(alpha_lin) * 27'(AlphaBias) + 27'd32768;
        aout_next = (t[26:16] > 11'(ChanMax)) ? ChanMax : t[23:16];
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_chan
        sab_isqrt u_isqrt
        (
            .clk      (clk),
            .ctrl     (ctrl),
            .radicand (wide_reg[c]),
            .root     (root[c])
        );
    end

    always_comb
    begin
        logic [RootW:0] t;
        pix_next = {adly_reg[SqrtStages-1], {(3*ChanW){1'b0}}};
        for (int c = 0; c < 3; c++)
        begin
            t = (RootW+1)'(root[c]) + (RootW+1)'(128);
            pix_next[ChanW*c +: ChanW] = (t[RootW:8] > (RootW-7)'(ChanMax)) ?
                                         ChanMax : t[15:8];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[StWide])
        begin
            wide_reg <= wide_next;
            aout_reg <= aout_next;
        end
        for (int k = 0; k < SqrtStages; k++)
        begin
            if (ctrl.load[StSqrt0 + k])
            begin
                adly_reg[k] <= (k == 0) ? aout_reg : adly_reg[(k == 0) ? 0 : k - 1];
            end
        end
        if (ctrl.load[StOut])
        begin
            pix_reg <= pix_next;
        end
    end

    assign blended_pixel = pix_reg;

endmodule

### rtl/core/srgb_alpha_over_blend_unit.sv
// top level of the gamma-2 premultiplied over blend pipeline
//
//  channel   dir  handshake             payload
//  input     in   in_valid / in_stall   src_pixel[31:0], dst_pixel[31:0]
//  output    out  out_valid / out_stall blended_pixel[31:0]
//  config    in   src_gain_we           src_gain[8:0]
//
// one pixel per clock sustained while out_stall is low; stages: lookup, scale, blend,
// wide multiply, six square root stages of three root bits each, pack
// every stage holds its own valid bit, so a stall at the output only backs up
// stages that are full and bubbles are squeezed out
// reset empties the pipeline and sets global alpha to 1.0; no clearing pass
module srgb_alpha_over_blend_unit import sab_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              src_gain_we,
    input  logic [GalW-1:0]   src_gain,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [PixW-1:0]   src_pixel,
    input  logic [PixW-1:0]   dst_pixel,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [PixW-1:0]   blended_pixel
);

    logic [GalW-1:0]       gal_reg, gal_next;
    logic [NumStages-1:0]  valid_reg, valid_next;
    logic [NumStages:0]    en;
    pipe_ctrl_t            ctrl;
    logic [2:0][SumW-1:0]  colour_lin;
    logic [SumW-1:0]       alpha_lin;

    // values above 1.0 clamp to 1.0
    assign gal_next = (src_gain > GalOne) ? GalOne : src_gain;

    // a stage may take new data when empty or when its content moves on
    always_comb
    begin
        en[NumStages] = !out_stall;
        for (int i = NumStages - 1; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < NumStages; i++)
        begin
            if (en[i])
            begin
                valid_next[i] = (i == 0) ? in_valid : valid_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    assign ctrl.load = en[NumStages-1:0];
    assign in_stall  = !en[0];
    assign out_valid = valid_reg[NumStages-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gal_reg   <= GalOne;
            valid_reg <= '0;
        end
        else
        begin
            if (src_gain_we)
            begin
                gal_reg <= gal_next;
            end
            valid_reg <= valid_next;
        end
    end

    sab_front u_front
    (
        .clk        (clk),
        .ctrl       (ctrl),
        .gal        (gal_reg),
        .src_pixel  (src_pixel),
        .dst_pixel  (dst_pixel),
        .colour_lin (colour_lin),
        .alpha_lin  (alpha_lin)
    );

    sab_back u_back
    (
        .clk           (clk),
        .ctrl          (ctrl),
        .colour_lin    (colour_lin),
        .alpha_lin     (alpha_lin),
        .blended_pixel (blended_pixel)
    );

    // input only backs up when every stage is full and the output is held
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> ((&valid_reg) && out_stall))
        else $error("input stalled with room in pipeline");

    a_gal_range: assert property (@(posedge clk) disable iff (!rst_n)
        gal_reg <= GalOne)
        else $error("global alpha above 1.0");

    // a held item in the first stage is not dropped
    a_first_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[0] && !en[1]) |=> valid_reg[0])
        else $error("first stage lost an item");

    // output valid only appears from the stage before
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(valid_reg[NumStages-1]) |-> $past(valid_reg[NumStages-2]))
        else $error("output valid without an item behind it");

endmodule

### verif/blend_pixel_checker.sv
// checker that predicts each blended pixel and compares it with the output transfers
module blend_pixel_checker import sab_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            src_gain_we,
    input  logic [GalW-1:0] src_gain,
    input  logic            in_valid,
    input  logic            in_stall,
    input  logic [PixW-1:0] src_pixel,
    input  logic [PixW-1:0] dst_pixel,
    input  logic            out_valid,
    input  logic            out_stall,
    input  logic [PixW-1:0] blended_pixel,
    output int              pending,
    output int              mismatches
);

    localparam longint unsigned Unity = 65536;

    logic [GalW-1:0] gain;
    logic [PixW-1:0] expected_pixels[$];
    logic [PixW-1:0] want;
    int              queued     = 0;
    int              fail_count = 0;

    assign pending    = queued;
    assign mismatches = fail_count;

    // (c/255)^2 in q1.16, rounded half up
    function automatic longint unsigned colour_lin(input logic [ChanW-1:0] c);
        longint unsigned sq;
        sq = c;
        sq = sq * sq * Unity;
        return (2 * sq + 65025) / 130050;
    endfunction

    function automatic longint unsigned alpha_lin(input logic [ChanW-1:0] a);
        longint unsigned n;
        n = a;
        return (2 * n * Unity + 255) / 510;
    endfunction

    function automatic longint unsigned int_root(input longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 20; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    // 255 * sqrt(x), rounded half up, clamped to a full channel
    function automatic logic [ChanW-1:0] lin_to_chan(input longint unsigned x);
        longint unsigned k;
        k = (int_root(65025 * x) + 128) >> 8;
        return (k > ChanMax) ? ChanMax : ChanW'(k);
    endfunction

    function automatic logic [PixW-1:0] over_blend(input logic [PixW-1:0] src,
                                                    input logic [PixW-1:0] dst,
                                                    input logic [GalW-1:0] g);
        longint unsigned sa;
        longint unsigned da;
        longint unsigned inv;
        longint unsigned a;
        longint unsigned s;
        longint unsigned d;
        logic [PixW-1:0] px;
        sa  = (alpha_lin(src[31:24]) * g + 128) >> 8;
        da  = alpha_lin(dst[31:24]);
        inv = Unity - sa;
        a   = sa + da - ((sa * da + 32768) >> 16);
        a   = (255 * a + 32768) >> 16;
        px[31:24] = (a > ChanMax) ? ChanMax : ChanW'(a);
        for (int k = 0; k < 3; k++)
        begin
            s = (colour_lin(src[8*k +: 8]) * g + 128) >> 8;
            d = colour_lin(dst[8*k +: 8]);
            px[8*k +: 8] = lin_to_chan(((inv * d + 32768) >> 16) + s);
        end
        return px;
    endfunction

    task automatic report_mismatch(input string what, input logic [PixW-1:0] got,
                                   input logic [PixW-1:0] exp_px);
        $display("mismatch %s: got %h, expected %h", what, got, exp_px);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain = GalOne;
            expected_pixels.delete();
            queued = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                    report_mismatch("unexpected transfer", blended_pixel, '0);
                else
                begin
                    want = expected_pixels.pop_front();
                    if (blended_pixel !== want)
                        report_mismatch("blended_pixel", blended_pixel, want);
                end
            end
            if (src_gain_we)
                gain = (src_gain > GalOne) ? GalOne : src_gain;
            if (in_valid && !in_stall)
                expected_pixels.push_back(over_blend(src_pixel, dst_pixel, gain));
            queued = expected_pixels.size();
        end
    end

endmodule

### verif/srgb_alpha_over_blend_unit_tb.sv
// testbench top: drives pixel transfers and global alpha writes into the blend unit
module srgb_alpha_over_blend_unit_tb import sab_pkg::*;
;

    logic            clk;
    logic            rst_n;
    logic            src_gain_we;
    logic [GalW-1:0] src_gain;
    logic            in_valid;
    logic            in_stall;
    logic [PixW-1:0] src_pixel;
    logic [PixW-1:0] dst_pixel;
    logic            out_valid;
    logic            out_stall;
    logic [PixW-1:0] blended_pixel;

    int pending;
    int mismatches;
    int snd_idle_pct = 24;
    int rcv_idle_pct = 70;
    int holds_asked  = 0;

    srgb_alpha_over_blend_unit dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .src_gain_we     (src_gain_we),
        .src_gain        (src_gain),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .src_pixel       (src_pixel),
        .dst_pixel       (dst_pixel),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .blended_pixel   (blended_pixel)
    );

    blend_pixel_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .src_gain_we     (src_gain_we),
        .src_gain        (src_gain),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .src_pixel       (src_pixel),
        .dst_pixel       (dst_pixel),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .blended_pixel   (blended_pixel),
        .pending         (pending),
        .mismatches      (mismatches)
    );

    initial
        clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #3000000;
        $display("TB_ERROR");
        $finish;
    end

    // output side: random stall, or a long hold-off when one is asked for
    initial
    begin
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        out_stall    = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && holds_served != holds_asked)
            begin
                holds_served++;
                hold_left = 120;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
        end
    end

    function automatic logic [ChanW-1:0] rand_chan();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return ChanMax;
            2:       return ChanW'($urandom_range(1, 16));
            3:       return ChanW'($urandom_range(240, 254));
            default: return ChanW'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [PixW-1:0] rand_pixel();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return {rand_chan(), rand_chan(), rand_chan(), rand_chan()};
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_pixel(input logic [PixW-1:0] src, input logic [PixW-1:0] dst);
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        src_pixel <= src;
        dst_pixel <= dst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);
    endtask

    task automatic write_gain(input logic [GalW-1:0] value);
        drain_results();
        src_gain_we <= 1'b1;
        src_gain    <= value;
        @(negedge clk);
        src_gain_we <= 1'b0;
    endtask

    initial
    begin
        logic [GalW-1:0] g;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        src_pixel   = '0;
        dst_pixel   = '0;
        src_gain_we = 1'b0;
        src_gain    = GalOne;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_gain(GalOne);
        send_pixel(32'h00000000, 32'h00000000);
        send_pixel(32'hffffffff, 32'hffffffff);
        send_pixel(32'hffffffff, 32'h00000000);
        send_pixel(32'h00000000, 32'hffffffff);
        // transparent but bright source is not premultiplied, colour saturates
        send_pixel(32'h00ffffff, 32'hffffffff);
        send_pixel(32'h80ffffff, 32'hff808080);
        send_pixel(32'h80ff00ff, 32'h00ffffff);
        send_pixel(32'haaaaaaaa, 32'h55555555);
        send_pixel(32'h55555555, 32'haaaaaaaa);
        send_pixel(32'h01010101, 32'hfefefefe);
        send_pixel(32'hff102030, 32'h80c0d0e0);
        send_pixel(32'h7f000000, 32'h7fffffff);
        write_gain(9'd0);
        send_pixel(32'hffffffff, 32'h80404040);
        send_pixel(32'hff000000, 32'h00000000);
        send_pixel(32'h00ffffff, 32'hff000000);
        // above one clamps to one
        write_gain(9'd511);
        send_pixel(32'h80ffffff, 32'hffffffff);
        send_pixel(32'hffffffff, 32'h00000000);
        send_pixel(32'h40808080, 32'hc0202020);
        write_gain(9'd257);
        send_pixel(32'h80ffffff, 32'hff000000);
        send_pixel(32'h01fefefe, 32'hfe010101);
        write_gain(9'd1);
        send_pixel(32'hffffffff, 32'hffffffff);
        send_pixel(32'hff808080, 32'h00000000);

        for (int seg = 0; seg < 12; seg++)
        begin
            case (seg % 6)
                0:       g = GalOne;
                1:       g = 9'd0;
                2:       g = 9'd128;
                3:       g = 9'd511;
                4:       g = 9'd255;
                default: g = GalW'($urandom_range(0, 511));
            endcase
            write_gain(g);
            snd_idle_pct = (seg < 4) ? 24 : (seg < 8) ? 70 : 0;
            rcv_idle_pct = (seg < 4) ? 70 : (seg < 8) ? 24 : 0;
            for (int i = 0; i < 158; i++)
            begin
                // long output hold-off while items keep coming, to back up the pipeline
                if ((seg == 1 || seg == 9) && i == 20)
                    holds_asked++;
                if (seg == 10 && i == 60)
                    drain_results();
                send_pixel(rand_pixel(), rand_pixel());
            end
        end

        drain_results();
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### srgb_alpha_over_blend_unit.f
rtl/core/sab_pkg.sv
rtl/core/sab_front.sv
rtl/core/sab_isqrt.sv
rtl/core/sab_back.sv
rtl/core/srgb_alpha_over_blend_unit.sv
verif/blend_pixel_checker.sv
verif/srgb_alpha_over_blend_unit_tb.sv
